/* hw/rtl/vff_pkg.sv */
// Package for the Vorbis float format converter: command codes and field constants.
// Depends on nothing; used by vorbis_float_format_converter.
package vff_pkg;

   typedef enum logic {
      CMD_UNPACK = 1'b0,
      CMD_PACK   = 1'b1
   } command_type;

   localparam int unsigned VF_BIAS    = 788;
   localparam logic [9:0]  VF_EXP_MAX = 10'h3FF;
   localparam logic [20:0] VF_ONE     = 21'h100000;

   // Position of the highest set bit of a 23-bit value (0 for zero).
   function automatic logic [4:0] top_bit(input logic [22:0] v);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

/* hw/rtl/vorbis_float_format_converter.sv */
// Top level of the Vorbis float format converter: unpack and pack in one registered pass.
// Depends on vff_pkg.
//
// One item is accepted per clock cycle whenever start is high; busy is held low because
// the block has no stall. Each item's result appears on the rsp_ ports in the cycle after
// acceptance, with rsp_valid high for a single cycle; the conversion is combinational from
// the request ports into the result register. The receiver cannot stall.
module vorbis_float_format_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_word_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_word_out,
   output logic        rsp_overflowed,
   output logic        rsp_not_finite_input
);

   logic        valid_ff;
   logic [31:0] word_ff, word_in;
   logic        ovf_ff, ovf_in, nf_ff, nf_in;

   // Unpack path.
   logic [20:0] u_m;
   logic [9:0]  u_e;
   logic [4:0]  u_p;
   logic signed [11:0] u_big_e;
   logic signed [11:0] u_sh;
   logic [4:0]  u_r;
   logic [20:0] u_rem, u_half;
   logic [22:0] u_q;
   logic [31:0] u_word;
   logic        u_ovf;
   logic [22:0] u_sig;

   // Pack path.
   logic [7:0]  p_be;
   logic [22:0] p_f;
   logic [4:0]  p_q;
   logic [4:0]  p_k;
   logic [20:0] p_mant;
   logic [9:0]  p_vexp;
   logic [31:0] p_word;
   logic        p_nf;
   logic [24:0] p_sum;

   always_comb begin
      u_m     = req_word_in[20:0];
      u_e     = req_word_in[30:21];
      u_p     = vff_pkg::top_bit({2'b00, u_m});
      u_big_e = $signed({7'd0, u_p}) + $signed({2'b00, u_e}) - 12'sd788;
      u_sh    = $signed({2'b00, u_e}) - 12'sd639;
      u_ovf   = 1'b0;
      u_r     = 5'd0;
      u_rem   = 21'd0;
      u_half  = 21'd0;
      u_q     = 23'd0;
      u_sig   = 23'({2'b00, u_m} << (5'd23 - u_p));
      if (u_m == 21'd0) begin
         u_word = 32'd0;
      end else if (u_big_e > 12'sd127) begin
         u_ovf  = 1'b1;
         u_word = {req_word_in[31], 31'h7F800000};
      end else if (u_big_e >= -12'sd126) begin
         u_word = {req_word_in[31], 8'(u_big_e + 12'sd127), u_sig[22:0]};
      end else begin
         // Subnormal result: shift the mantissa into units of 2^-149 and round to even.
         if (u_sh >= 12'sd0) begin
            u_q = 23'({2'b00, u_m} << u_sh[4:0]);
         end else if (u_sh <= -12'sd22) begin
            u_q = 23'd0;
         end else begin
            u_r    = 5'(-u_sh);
            u_half = 21'd1 << (u_r - 5'd1);
            u_rem  = u_m & ((21'd1 << u_r) - 21'd1);
            u_q    = {2'b00, u_m >> u_r};
            if (u_rem > u_half || (u_rem == u_half && u_q[0])) u_q = u_q + 23'd1;
         end
         u_word = {req_word_in[31], 8'd0, u_q};
      end
   end

   always_comb begin
      p_be   = req_word_in[30:23];
      p_f    = req_word_in[22:0];
      p_q    = vff_pkg::top_bit(p_f);
      p_k    = p_q - 5'd19;
      p_nf   = 1'b0;
      p_mant = 21'd0;
      p_vexp = 10'd0;
      p_sum  = 25'd0;
      if (p_be == 8'hFF) begin
         p_nf   = 1'b1;
         p_word = {req_word_in[31], vff_pkg::VF_EXP_MAX, vff_pkg::VF_ONE};
      end else if (p_be == 8'd0 && p_f == 23'd0) begin
         p_word = 32'd0;
      end else begin
         if (p_be != 8'd0) begin
            p_sum  = {2'b01, p_f} + 25'd8;
            p_mant = 21'(p_sum >> 4);
            p_vexp = 10'({2'b00, p_be} + 10'd642);
         end else begin
            if (p_q <= 5'd19) begin
               p_mant = 21'(p_f << (5'd19 - p_q));
            end else begin
               p_sum  = {2'b00, p_f} + (25'd1 << (p_k - 5'd1));
               p_mant = 21'(p_sum >> p_k);
            end
            p_vexp = 10'({5'd0, p_q} + 10'd620);
         end
         p_word = {req_word_in[31], p_vexp, p_mant};
      end
   end

   always_comb begin
      if (req_command == vff_pkg::CMD_PACK) begin
         word_in = p_word;
         ovf_in  = 1'b0;
         nf_in   = p_nf;
      end else begin
         word_in = u_word;
         ovf_in  = u_ovf;
         nf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      word_ff <= word_in;
      ovf_ff  <= ovf_in;
      nf_ff   <= nf_in;
   end

   assign busy                 = 1'b0;
   assign rsp_valid            = valid_ff;
   assign rsp_word_out         = word_ff;
   assign rsp_overflowed       = ovf_ff;
   assign rsp_not_finite_input = nf_ff;

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflowed && rsp_not_finite_input))
      else $error("both result flags set");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_valid)
      else $error("accepted item produced no result");
   a_ovf_inf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflowed) |-> (rsp_word_out[30:0] == 31'h7F800000))
      else $error("overflow without infinity");

endmodule
